// File: rtl/lir_pkg.sv
// Shared constants, types and width helpers of the linear interpolation resampler.
`default_nettype none

package lir_pkg;

  // Rate registers and configuration port
  localparam int RATE_W     = 19;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_RATE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_RATE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STEREO_MODE = 2'd2;

  localparam logic [RATE_W-1:0] RESET_RATE   = 19'd44100;
  localparam logic              RESET_STEREO = 1'b1;

  // Parameter defaults
  localparam int DEF_MAX_BURST    = 64;
  localparam int DEF_SAMPLE_WIDTH = 16;

  // Request to the shared divider
  typedef struct packed {
    logic start;     // load operands and begin
    logic mod_mode;  // remainder of a rate-sized dividend, else interpolation quotient
  } div_req_t;

  // Signed width of y0*den + (y1-y0)*r
  function automatic int acc_width(int sw);
    return sw + RATE_W + 2;
  endfunction

  // Working width of the divider remainder and shifted divisor
  function automatic int div_width(int sw);
    return (sw + RATE_W + 2 > 2 * RATE_W) ? sw + RATE_W + 2 : 2 * RATE_W;
  endfunction

  // Largest divisor shift, i.e. number of quotient bits minus one
  function automatic int div_top_shift(int sw);
    return (sw > RATE_W - 1) ? sw : RATE_W - 1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lir_div.sv
// Restoring divider, one quotient bit per cycle, shared for interpolation and phase skip.
`default_nettype none

module lir_div #(
  parameter  int SW = lir_pkg::DEF_SAMPLE_WIDTH,
  localparam int DW = lir_pkg::div_width(SW),
  localparam int QW = lir_pkg::div_top_shift(SW) + 1
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  lir_pkg::div_req_t              req,
  input  wire  [DW-1:0]                  dividend,
  input  wire  [lir_pkg::RATE_W-1:0]     divisor,
  output logic                           done,
  output logic [QW-1:0]                  quotient,
  output logic [DW-1:0]                  remainder
);
  import lir_pkg::*;

  localparam int TOP = div_top_shift(SW);
  localparam int CW  = $clog2(TOP + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic          ge;

  assign ge = (rem_r >= dvs_r);

  // Load on start, then compare-subtract with the divisor walking down one bit
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = dividend;
      q_nxt    = '0;
      if (req.mod_mode) begin
        dvs_nxt = DW'(divisor) << (RATE_W - 1);
        cnt_nxt = CW'(RATE_W - 1);
      end else begin
        dvs_nxt = DW'(divisor) << SW;
        cnt_nxt = CW'(SW);
      end
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_r - dvs_r) : rem_r;
      q_nxt   = {q_r[QW-2:0], ge};
      dvs_nxt = dvs_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// File: rtl/linear_interp_resampler.sv
// Linear interpolation sample rate converter with exact rational phase.
// Each result passes a check state, then for each channel the one shared multiplier and
// the bit-serial divider; each segment that overflows the burst limit adds a divider pass
// that skips the dropped results.
// A new input word is taken once the previous one has queued its last result.
// Synchronous active-low reset restores default rates, stereo mode and an empty stream.
`default_nettype none

module linear_interp_resampler #(
  parameter  int MAX_BURST    = lir_pkg::DEF_MAX_BURST,
  parameter  int SAMPLE_WIDTH = lir_pkg::DEF_SAMPLE_WIDTH,
  localparam int DATA_W       = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // input frames: tdata = left_sample, right_sample, zero pad; tlast = final_frame
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [DATA_W-1:0]                in_tdata,
  input  wire                              in_tlast,
  // results: tdata = left_out, right_out, zero pad; tlast = run_end
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [DATA_W-1:0]                out_tdata,
  output logic                             out_tlast,
  // tuser = stream_end, burst_overflow
  output logic [1:0]                       out_tuser,
  // register writes
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [lir_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire  [lir_pkg::RATE_W-1:0]       cfg_data
);
  import lir_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int ACCW  = acc_width(SW);
  localparam int DW    = div_width(SW);
  localparam int QW    = div_top_shift(SW) + 1;
  localparam int CNT_W = $clog2(MAX_BURST + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_MUL0    = 4'd2;
  localparam logic [3:0] S_MUL1    = 4'd3;
  localparam logic [3:0] S_DIVGO   = 4'd4;
  localparam logic [3:0] S_DIVWAIT = 4'd5;
  localparam logic [3:0] S_MODGO   = 4'd6;
  localparam logic [3:0] S_MODWAIT = 4'd7;
  localparam logic [3:0] S_SEGEND  = 4'd8;
  localparam logic [3:0] S_FINISH  = 4'd9;

  // Control state
  logic [3:0]        state_r, state_nxt;
  logic [RATE_W-1:0] src_r, src_nxt;
  logic [RATE_W-1:0] tgt_r, tgt_nxt;
  logic              stereo_r, stereo_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [RATE_W-1:0] phase_r, phase_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Datapath
  logic signed [SW-1:0]   prev_l_r, prev_l_nxt, prev_r_r, prev_r_nxt;
  logic signed [SW-1:0]   cur_l_r, cur_l_nxt, cur_r_r, cur_r_nxt;
  logic                   fin_r, fin_nxt;
  logic                   seg_r, seg_nxt;
  logic                   ch_r, ch_nxt;
  logic                   over_r, over_nxt;
  logic [RATE_W:0]        p_r, p_nxt;
  logic signed [ACCW-1:0] acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic signed [SW-1:0]   pend_l_r, pend_l_nxt, pend_r_r, pend_r_nxt;
  logic signed [SW-1:0]   out_l_r, out_l_nxt, out_r_r, out_r_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_send_r, out_send_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  // Derived values
  logic [RATE_W-1:0]      step, den, rem_lo;
  logic [RATE_W:0]        den_ext;
  logic                   out_free, burst_room, have_result, pend_push;
  logic signed [SW-1:0]   y0, y1, cur_ch, prev_ch, div_res;
  logic signed [SW:0]     mul_a;
  logic signed [RATE_W:0] mul_b;
  logic signed [ACCW-1:0] mul_p;
  logic [ACCW-1:0]        acc_mag;
  logic [SW-1:0]          q_lo;

  // Divider interface
  div_req_t          div_req;
  logic [DW-1:0]     div_dividend;
  logic              div_done;
  logic [QW-1:0]     div_q;
  logic [DW-1:0]     div_rem;

  assign step    = (src_r == '0) ? RATE_W'(1) : src_r;
  assign den     = (tgt_r == '0) ? RATE_W'(1) : tgt_r;
  assign den_ext = {1'b0, den};

  assign out_free    = !out_valid_r || out_tready;
  assign burst_room  = (cnt_r < CNT_W'(MAX_BURST));
  assign have_result = (p_r < den_ext);

  // Channel and segment operand selection
  assign cur_ch  = ch_r ? cur_r_r : cur_l_r;
  assign prev_ch = ch_r ? prev_r_r : prev_l_r;
  assign y0      = seg_r ? cur_ch : prev_ch;
  assign y1      = cur_ch;

  // Shared multiplier: y0*den first, then (y1-y0)*phase
  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = {y1[SW-1], y1} - {y0[SW-1], y0};
      mul_b = {1'b0, p_r[RATE_W-1:0]};
    end else begin
      mul_a = {y0[SW-1], y0};
      mul_b = {1'b0, den};
    end
  end
  assign mul_p = mul_a * mul_b;

  assign acc_mag = acc_r[ACCW-1] ? ACCW'(-acc_r) : acc_r;
  assign q_lo    = div_q[SW-1:0];
  assign div_res = neg_r ? $signed(-q_lo) : $signed(q_lo);
  assign rem_lo  = div_rem[RATE_W-1:0];

  // Divider operands
  assign div_req.start    = (state_r == S_DIVGO) || (state_r == S_MODGO);
  assign div_req.mod_mode = (state_r == S_MODGO);
  assign div_dividend     = (state_r == S_MODGO) ? DW'(den - p_r[RATE_W-1:0])
                                                 : DW'(acc_mag);

  lir_div #(.SW(SW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   ((state_r == S_MODGO) ? step : den),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    src_nxt        = src_r;
    tgt_nxt        = tgt_r;
    stereo_nxt     = stereo_r;
    have_prev_nxt  = have_prev_r;
    phase_nxt      = phase_r;
    pend_valid_nxt = pend_valid_r;
    cnt_nxt        = cnt_r;
    prev_l_nxt     = prev_l_r;
    prev_r_nxt     = prev_r_r;
    cur_l_nxt      = cur_l_r;
    cur_r_nxt      = cur_r_r;
    fin_nxt        = fin_r;
    seg_nxt        = seg_r;
    ch_nxt         = ch_r;
    over_nxt       = over_r;
    p_nxt          = p_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    pend_l_nxt     = pend_l_r;
    pend_r_nxt     = pend_r_r;
    out_l_nxt      = out_l_r;
    out_r_nxt      = out_r_r;
    out_last_nxt   = out_last_r;
    out_send_nxt   = out_send_r;
    out_ovf_nxt    = out_ovf_r;
    pend_push      = 1'b0;

    // register writes
    if (cfg_valid) begin
      unique case (cfg_addr)
        REG_SOURCE_RATE: src_nxt    = cfg_data;
        REG_TARGET_RATE: tgt_nxt    = cfg_data;
        REG_STEREO_MODE: stereo_nxt = cfg_data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cur_l_nxt = in_tdata[SW-1:0];
          cur_r_nxt = in_tdata[2*SW-1:SW];
          fin_nxt   = in_tlast;
          p_nxt     = {1'b0, phase_r};
          cnt_nxt   = '0;
          over_nxt  = 1'b0;
          if (have_prev_r) begin
            seg_nxt   = 1'b0;
            state_nxt = S_CHECK;
          end else if (in_tlast) begin
            seg_nxt   = 1'b1;
            state_nxt = S_CHECK;
          end else begin
            // first frame of a stream: just hold it
            prev_l_nxt    = in_tdata[SW-1:0];
            prev_r_nxt    = in_tdata[2*SW-1:SW];
            have_prev_nxt = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (have_result && burst_room) begin
          // another result follows, so the pending one is not the last
          if (!pend_valid_r || out_free) begin
            pend_push = pend_valid_r;
            if (pend_valid_r) begin
              out_last_nxt = 1'b0;
              out_send_nxt = 1'b0;
              out_ovf_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b0;
            ch_nxt         = 1'b0;
            state_nxt      = S_MUL0;
          end
        end else if (have_result) begin
          over_nxt  = 1'b1;
          state_nxt = S_MODGO;
        end else begin
          p_nxt     = p_r - den_ext;
          state_nxt = S_SEGEND;
        end
      end
      S_MUL0: begin
        acc_nxt   = mul_p;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        acc_nxt   = acc_r + mul_p;
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        neg_nxt   = acc_r[ACCW-1];
        state_nxt = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (div_done) begin
          if (!ch_r) begin
            pend_l_nxt = div_res;
          end else begin
            pend_r_nxt = div_res;
          end
          if (!ch_r && stereo_r) begin
            ch_nxt    = 1'b1;
            state_nxt = S_MUL0;
          end else begin
            if (!stereo_r) begin
              pend_r_nxt = '0;
            end
            pend_valid_nxt = 1'b1;
            cnt_nxt        = cnt_r + 1'b1;
            p_nxt          = p_r + {1'b0, step};
            state_nxt      = S_CHECK;
          end
        end
      end
      S_MODGO: begin
        state_nxt = S_MODWAIT;
      end
      S_MODWAIT: begin
        // phase past the frame after skipping the dropped results
        if (div_done) begin
          p_nxt     = (rem_lo == '0) ? '0 : {1'b0, step - rem_lo};
          state_nxt = S_SEGEND;
        end
      end
      S_SEGEND: begin
        if (!seg_r && fin_r) begin
          seg_nxt   = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!pend_valid_r || out_free) begin
          pend_push = pend_valid_r;
          // flags go with the pushed word only; a waiting word keeps its own
          if (pend_valid_r) begin
            out_last_nxt = 1'b1;
            out_send_nxt = fin_r;
            out_ovf_nxt  = over_r;
          end
          pend_valid_nxt = 1'b0;
          if (fin_r) begin
            have_prev_nxt = 1'b0;
            phase_nxt     = '0;
          end else begin
            prev_l_nxt    = cur_l_r;
            prev_r_nxt    = cur_r_r;
            have_prev_nxt = 1'b1;
            phase_nxt     = p_r[RATE_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // output word register
    if (pend_push) begin
      out_valid_nxt = 1'b1;
      out_l_nxt     = pend_l_r;
      out_r_nxt     = pend_r_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      src_r        <= RESET_RATE;
      tgt_r        <= RESET_RATE;
      stereo_r     <= RESET_STEREO;
      have_prev_r  <= 1'b0;
      phase_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      src_r        <= src_nxt;
      tgt_r        <= tgt_nxt;
      stereo_r     <= stereo_nxt;
      have_prev_r  <= have_prev_nxt;
      phase_r      <= phase_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prev_l_r   <= prev_l_nxt;
    prev_r_r   <= prev_r_nxt;
    cur_l_r    <= cur_l_nxt;
    cur_r_r    <= cur_r_nxt;
    fin_r      <= fin_nxt;
    seg_r      <= seg_nxt;
    ch_r       <= ch_nxt;
    over_r     <= over_nxt;
    p_r        <= p_nxt;
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    pend_l_r   <= pend_l_nxt;
    pend_r_r   <= pend_r_nxt;
    out_l_r    <= out_l_nxt;
    out_r_r    <= out_r_nxt;
    out_last_r <= out_last_nxt;
    out_send_r <= out_send_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'({out_r_r, out_l_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_send_r};

  // Checks
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_valid_r)
    else $error("pending result left behind when going idle");

  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BURST))
    else $error("result count exceeds burst limit");

  a_flags_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[0] || out_tuser[1])) |-> out_tlast)
    else $error("stream end or overflow flag on a word that is not last");

  a_weight_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL1) |-> (p_r < den_ext))
    else $error("interpolation weight not below target rate");

endmodule

`default_nettype wire
